@@ rtl/obst_pkg.sv @@
// Shared types, codes and widths of the optimal search tree block.
package obst_pkg;

  localparam int MAX_KEYS_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int KEY_W           = 5;
  localparam int REL_W           = 2;
  localparam int COST_W          = 26;

  localparam logic [REL_W-1:0] REL_ROOT  = 2'd0;
  localparam logic [REL_W-1:0] REL_LEFT  = 2'd1;
  localparam logic [REL_W-1:0] REL_RIGHT = 2'd2;
  localparam logic [REL_W-1:0] REL_EMPTY = 2'd3;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CELL_RD,
    S_CELL_W,
    S_CAND,
    S_CELL_WR,
    S_LIST_RD,
    S_LIST_TOT,
    S_EMPTY,
    S_POP,
    S_ROOT,
    S_EMIT,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic cell_rd;
    logic cell_w;
    logic cand;
    logic cell_wr;
    logic list_rd;
    logic list_tot;
    logic pop;
    logic root;
    logic emit;
    logic emit_empty;
    logic push_l;
  } cmd_t;

  typedef struct packed {
    logic load_empty;
    logic r_done;
    logic cell_last;
    logic span_empty;
    logic pop_done;
  } sts_t;

endpackage

@@ rtl/obst_ctrl.sv @@
// Sequencer for loading, table fill and preorder listing.
module obst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last,
  input  obst_pkg::sts_t sts,
  output obst_pkg::cmd_t cmd,
  output logic          busy
);
  import obst_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (start && last) begin
          state_next = sts.load_empty ? S_LIST_RD : S_CELL_RD;
        end
      end
      S_CELL_RD:  state_next = S_CELL_W;
      S_CELL_W:   state_next = S_CAND;
      S_CAND: begin
        if (sts.r_done) begin
          state_next = S_CELL_WR;
        end
      end
      S_CELL_WR:  state_next = sts.cell_last ? S_LIST_RD : S_CELL_RD;
      S_LIST_RD:  state_next = S_LIST_TOT;
      S_LIST_TOT: state_next = sts.span_empty ? S_EMPTY : S_POP;
      S_EMPTY:    state_next = S_LOAD;
      S_POP:      state_next = sts.pop_done ? S_LOAD : S_ROOT;
      S_ROOT:     state_next = S_EMIT;
      S_EMIT:     state_next = S_PUSH;
      S_PUSH:     state_next = S_POP;
      default:    state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd            = '0;
    busy           = 1'b1;
    case (state)
      S_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_CELL_RD:  cmd.cell_rd    = 1'b1;
      S_CELL_W:   cmd.cell_w     = 1'b1;
      S_CAND:     cmd.cand       = 1'b1;
      S_CELL_WR:  cmd.cell_wr    = 1'b1;
      S_LIST_RD:  cmd.list_rd    = 1'b1;
      S_LIST_TOT: cmd.list_tot   = 1'b1;
      S_EMPTY:    cmd.emit_empty = 1'b1;
      S_POP:      cmd.pop        = !sts.pop_done;
      S_ROOT:     cmd.root       = 1'b1;
      S_EMIT:     cmd.emit       = 1'b1;
      S_PUSH:     cmd.push_l     = 1'b1;
      default:    cmd            = '0;
    endcase
  end

endmodule

@@ rtl/obst_dp.sv @@
// Datapath: weight stores, cost, weight and root tables, walk stack, result register.
module obst_dp #(
  parameter int MAX_KEYS    = obst_pkg::MAX_KEYS_DEF,
  parameter int WEIGHT_BITS = obst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  obst_pkg::cmd_t                cmd,
  input  logic [WEIGHT_BITS-1:0]        key_weight,
  input  logic [WEIGHT_BITS-1:0]        gap_weight,
  input  logic                          last,
  output obst_pkg::sts_t                sts,
  output logic                          result_strobe,
  output logic [obst_pkg::KEY_W-1:0]    key,
  output logic [obst_pkg::KEY_W-1:0]    parent,
  output logic [obst_pkg::REL_W-1:0]    relation,
  output logic [obst_pkg::COST_W-1:0]   total_cost,
  output logic                          last_res
);
  import obst_pkg::*;

  localparam int IW   = $clog2(MAX_KEYS + 3);
  localparam int CW   = $clog2(MAX_KEYS + 2);
  localparam int SW   = $clog2(MAX_KEYS + 1);
  localparam int AW   = 2 * IW;
  localparam int WT_W = WEIGHT_BITS + $clog2(2 * MAX_KEYS + 2);
  localparam int KG_W = WEIGHT_BITS + 1;
  localparam int TW   = ((COST_W > WT_W) ? COST_W : WT_W) + 2;
  localparam int EW   = 3 * IW;
  localparam logic [SW:0] MAX_CNT = (SW + 1)'(MAX_KEYS);

  logic [COST_W-1:0] cost_mem [0:2**AW-1];
  logic [WT_W-1:0]   wt_mem   [0:2**AW-1];
  logic [IW-1:0]     root_mem [0:2**AW-1];
  logic [KG_W-1:0]   kg_mem   [0:2**IW-1];
  logic [EW-1:0]     stk_mem  [0:MAX_KEYS];

  logic [CW-1:0]     cnt;
  logic [IW-1:0]     n, len, i, j, r, broot, e_lo, e_hi, e_up;
  logic [WT_W-1:0]   w;
  logic [COST_W-1:0] best, total;
  logic [SW-1:0]     sp, count;

  logic [COST_W-1:0] ca_rd, cb_rd;
  logic [WT_W-1:0]   w_rd;
  logic [KG_W-1:0]   kg_rd;
  logic [IW-1:0]     node;
  logic [EW-1:0]     stk_rd;

  logic              stor;
  logic [IW-1:0]     rn;
  logic [AW-1:0]     caa, cba, cwa;
  logic [COST_W-1:0] cwd;
  logic              cwe, wwe, swe;
  logic [WT_W-1:0]   w_sum, wwd;
  logic [TW-1:0]     t;
  logic              take, push_r, push_l;
  logic [SW-1:0]     swa;
  logic [EW-1:0]     swd;
  logic [SW:0]       sp_after;

  assign stor   = cnt <= CW'(MAX_KEYS);
  assign rn     = cmd.cand ? IW'(r + 1'b1) : i;
  assign caa    = cmd.list_rd ? {IW'(1), n} : {i, IW'(rn - 1'b1)};
  assign cba    = {IW'(rn + 1'b1), j};
  assign cwa    = cmd.load ? {IW'(IW'(cnt) + 1'b1), IW'(cnt)} : {i, j};
  assign cwd    = cmd.load ? COST_W'(gap_weight) : best;
  assign cwe    = (cmd.load && stor) || cmd.cell_wr;
  assign w_sum  = w_rd + WT_W'(kg_rd);
  assign wwd    = cmd.load ? WT_W'(gap_weight) : w_sum;
  assign wwe    = (cmd.load && stor) || cmd.cell_w;
  assign t      = TW'(ca_rd) + TW'(cb_rd) + TW'(w);
  assign take   = t <= TW'(best);
  assign push_r = node < e_hi;
  assign push_l = node > e_lo;
  assign sp_after = (SW + 1)'(sp) + (SW + 1)'(push_r) + (SW + 1)'(push_l);

  always_comb begin
    swa = sp;
    swd = {IW'(node + 1'b1), e_hi, node};
    swe = cmd.emit && push_r;
    if (cmd.list_rd) begin
      swa = '0;
      swd = {IW'(1), n, IW'(0)};
      swe = 1'b1;
    end else if (cmd.push_l) begin
      swd = {e_lo, IW'(node - 1'b1), node};
      swe = push_l;
    end
  end

  // table memories, registered reads
  always_ff @(posedge clk) begin
    if (cwe) begin
      cost_mem[cwa] <= cwd;
    end
    ca_rd <= cost_mem[caa];
    cb_rd <= cost_mem[cba];
    if (wwe) begin
      wt_mem[cwa] <= wwd;
    end
    if (cmd.cell_rd) begin
      w_rd  <= wt_mem[{i, IW'(j - 1'b1)}];
      kg_rd <= kg_mem[j];
    end
    if (cmd.load && stor) begin
      kg_mem[IW'(cnt)] <= KG_W'(key_weight) + KG_W'(gap_weight);
    end
    if (cmd.cell_wr) begin
      root_mem[{i, j}] <= broot;
    end
    if (cmd.root) begin
      node <= root_mem[{stk_rd[EW-1 -: IW], stk_rd[2*IW-1 -: IW]}];
    end
    if (swe) begin
      stk_mem[swa] <= swd;
    end
    stk_rd <= stk_mem[SW'(sp - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit || cmd.emit_empty;
      if (cmd.load) begin
        if (last) begin
          cnt <= '0;
        end else if (stor) begin
          cnt <= CW'(cnt + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && last) begin
      n   <= stor ? IW'(cnt) : IW'(MAX_KEYS);
      len <= IW'(1);
      i   <= IW'(1);
      j   <= IW'(1);
    end
    if (cmd.cell_w) begin
      w     <= w_sum;
      best  <= '1;
      broot <= i;
      r     <= i;
    end
    if (cmd.cand) begin
      if (take) begin
        best  <= COST_W'(t);
        broot <= r;
      end
      r <= IW'(r + 1'b1);
    end
    if (cmd.cell_wr) begin
      // next span length once the row end is reached
      if (j == n) begin
        len <= IW'(len + 1'b1);
        i   <= IW'(1);
        j   <= IW'(len + 1'b1);
      end else begin
        i <= IW'(i + 1'b1);
        j <= IW'(j + 1'b1);
      end
    end
    if (cmd.list_rd) begin
      sp    <= SW'(1);
      count <= '0;
    end
    if (cmd.list_tot) begin
      total <= ca_rd;
    end
    if (cmd.pop) begin
      sp <= SW'(sp - 1'b1);
    end
    if (cmd.root) begin
      e_lo <= stk_rd[EW-1 -: IW];
      e_hi <= stk_rd[2*IW-1 -: IW];
      e_up <= stk_rd[IW-1:0];
    end
    if (cmd.emit) begin
      key        <= KEY_W'(node);
      parent     <= KEY_W'(e_up);
      relation   <= (e_up == '0) ? REL_ROOT : ((node < e_up) ? REL_LEFT : REL_RIGHT);
      total_cost <= total;
      last_res   <= (sp_after == '0) || ((SW + 1)'(count) + 1'b1 == MAX_CNT);
      count      <= SW'(count + 1'b1);
      sp         <= SW'(sp + push_r);
    end
    if (cmd.push_l && push_l) begin
      sp <= SW'(sp + 1'b1);
    end
    if (cmd.emit_empty) begin
      key        <= '0;
      parent     <= '0;
      relation   <= REL_EMPTY;
      total_cost <= total;
      last_res   <= 1'b1;
    end
  end

  assign sts.load_empty = cnt == '0;
  assign sts.r_done     = r == j;
  assign sts.cell_last  = len == n;
  assign sts.span_empty = n == '0;
  assign sts.pop_done   = (sp == '0) || ((SW + 1)'(count) == MAX_CNT);

endmodule

@@ rtl/optimal_bst_dp.sv @@
// Top level of the optimal binary search tree solver.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | start & !busy          | key_weight, gap_weight, last
//  result   | result_strobe (1 cyc)  | key, parent, relation, total_cost, last_res
//
// A beat without last keeps the block loading for the next beat. After last the tables
// are filled one span at a time, unless no key was loaded: each cell reads its weights,
// then tries one candidate root a cycle through the single adder and comparator fed by
// the two cost table read ports, then writes. The listing then reads the total and emits
// the keys from the walk stack. Reset is synchronous and clears the item count, result
// strobe and sequencer only. The receiver cannot stall; busy holds off new beats.
module optimal_bst_dp #(
  parameter int MAX_KEYS    = obst_pkg::MAX_KEYS_DEF,
  parameter int WEIGHT_BITS = obst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [WEIGHT_BITS-1:0]        key_weight,
  input  logic [WEIGHT_BITS-1:0]        gap_weight,
  input  logic                          last,
  output logic                          result_strobe,
  output logic [obst_pkg::KEY_W-1:0]    key,
  output logic [obst_pkg::KEY_W-1:0]    parent,
  output logic [obst_pkg::REL_W-1:0]    relation,
  output logic [obst_pkg::COST_W-1:0]   total_cost,
  output logic                          last_res
);
  import obst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  obst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  obst_dp #(
    .MAX_KEYS    (MAX_KEYS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .key_weight    (key_weight),
    .gap_weight    (gap_weight),
    .last          (last),
    .sts           (sts),
    .result_strobe (result_strobe),
    .key           (key),
    .parent        (parent),
    .relation      (relation),
    .total_cost    (total_cost),
    .last_res      (last_res)
  );

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result beats back to back");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last |=> !busy && !result_strobe)
    else $error("non-final beat left the loading phase");

  a_empty_tree: assert property (@(posedge clk) disable iff (rst)
    result_strobe && relation == REL_EMPTY |-> last_res && key == '0)
    else $error("empty tree result malformed");

endmodule
